// ----- hw/rtl/tdl_pkg.sv -----
// shared types and constants of the touch-dim light channel controller
package tdl_pkg;

	localparam int ADDR_W    = 7;
	localparam int LEVEL_W   = 8;
	localparam int ACT_W     = 8;
	localparam int KIND_W    = 2;
	localparam int FLAG_W    = 4;
	localparam int ENTRY_W   = FLAG_W + LEVEL_W;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 8;
	localparam int DIV_NUM_W = 2 * LEVEL_W;
	localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

	typedef enum logic [1:0] {
		OP_BUTTON    = 2'd0,
		OP_SET_LEVEL = 2'd1,
		OP_TOGGLE    = 2'd2,
		OP_TICK      = 2'd3
	} op_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_ARC    = 2'd0,
		KIND_OFF    = 2'd1,
		KIND_REPORT = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		VS_ZERO   = 2'd0,
		VS_NEW    = 2'd1,
		VS_SCALED = 2'd2,
		VS_INPUT  = 2'd3
	} val_sel_t;

	localparam logic [ACT_W-1:0] BTN_OPEN   = 8'h00;
	localparam logic [ACT_W-1:0] BTN_CLOSED = 8'hff;
	localparam logic [ACT_W-1:0] BTN_SHORT  = 8'hfc;
	localparam logic [ACT_W-1:0] BTN_HELD   = 8'hfe;

	localparam logic [CFG_IDX_W-1:0] CFG_LOWER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP  = 2'd2;

	localparam logic [LEVEL_W-1:0] LOWER_RST  = 8'd149;
	localparam logic [LEVEL_W-1:0] UPPER_RST  = 8'd254;
	localparam logic [LEVEL_W-1:0] STEP_RST   = 8'd4;
	localparam logic [LEVEL_W-1:0] SCALE_FULL = 8'd254;
	localparam logic [LEVEL_W-1:0] REPORT_MAX = 8'd255;

	localparam int F_ON      = 0;
	localparam int F_UP      = 1;
	localparam int F_DOWN    = 2;
	localparam int F_LAST_UP = 3;
	localparam logic [FLAG_W-1:0]  FLAGS_RST = 4'b1000;
	localparam logic [LEVEL_W-1:0] LEVEL_RST = UPPER_RST;

	localparam logic [ADDR_W-1:0] BROADCAST_ADDR = 7'd127;

	typedef struct packed {
		logic cap;
		logic mem_rd;
		logic dec;
		logic mul;
		logic div_start;
		logic fin;
		logic wb;
		logic out_load;
		logic out_sel;
	} tdl_cmd_t;

	typedef struct packed {
		logic       addr_ok;
		logic       need_div;
		logic [1:0] res_cnt;
		logic       div_busy;
		logic       out_free;
	} tdl_sts_t;

endpackage

// ----- hw/rtl/tdl_if.sv -----
// request and result channel interfaces
interface tdl_req_if;
	import tdl_pkg::*;

	logic               valid;
	logic               ready;
	logic [1:0]         operation;
	logic [ADDR_W-1:0]  address;
	logic [ACT_W-1:0]   touch_code;
	logic [LEVEL_W-1:0] level;

	modport source (output valid, output operation, output address, output touch_code,
		output level, input ready);
	modport sink (input valid, input operation, input address, input touch_code,
		input level, output ready);
endinterface

interface tdl_rsp_if;
	import tdl_pkg::*;

	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  kind;
	logic [ADDR_W-1:0]  channel;
	logic [LEVEL_W-1:0] value;
	logic               last;

	modport source (output valid, output kind, output channel, output value, output last,
		input ready);
	modport sink (input valid, input kind, input channel, input value, input last,
		output ready);
endinterface

// ----- hw/rtl/tdl_div.sv -----
// iterative restoring divider, one quotient bit per cycle
module tdl_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [tdl_pkg::DIV_NUM_W-1:0]   num,
	input  logic [tdl_pkg::LEVEL_W-1:0]     den,
	output logic                            busy,
	output logic [tdl_pkg::DIV_NUM_W-1:0]   quo
);
	import tdl_pkg::*;

	logic [DIV_NUM_W-1:0] quo_q;
	logic [LEVEL_W:0]     rem_q;
	logic [LEVEL_W-1:0]   den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [LEVEL_W:0]     rem_sh;
	logic                 geq;

	assign rem_sh = {rem_q[LEVEL_W-1:0], quo_q[DIV_NUM_W-1]};
	assign geq    = rem_sh >= {1'b0, den_q};
	assign busy   = cnt_q != '0;
	assign quo    = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= DIV_CNT_W'(DIV_NUM_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// numerator shifts out the top while quotient bits shift in at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy) begin
			quo_q <= {quo_q[DIV_NUM_W-2:0], geq};
			rem_q <= geq ? (rem_sh - {1'b0, den_q}) : rem_sh;
		end
	end

endmodule

// ----- hw/rtl/tdl_dp.sv -----
// datapath: channel memory, decode, scaling arithmetic and result register
module tdl_dp #(
	parameter int CHANNEL_COUNT = 81
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tdl_pkg::tdl_cmd_t               cmd,
	output tdl_pkg::tdl_sts_t               sts,
	input  logic                            cfg_we,
	input  logic [tdl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tdl_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic [1:0]                      req_operation,
	input  logic [tdl_pkg::ADDR_W-1:0]      req_address,
	input  logic [tdl_pkg::ACT_W-1:0]       req_touch_code,
	input  logic [tdl_pkg::LEVEL_W-1:0]     req_level,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output logic [tdl_pkg::KIND_W-1:0]      rsp_kind,
	output logic [tdl_pkg::ADDR_W-1:0]      rsp_channel,
	output logic [tdl_pkg::LEVEL_W-1:0]     rsp_value,
	output logic                            rsp_last
);
	import tdl_pkg::*;

	localparam int IDX_W = $clog2(CHANNEL_COUNT);
	localparam logic [IDX_W-1:0] BCAST_ENTRY = IDX_W'(CHANNEL_COUNT - 1);

	typedef struct packed {
		logic [1:0]         res_cnt;
		kind_t              kind0;
		kind_t              kind1;
		val_sel_t           sel0;
		val_sel_t           sel1;
		logic               need_div;
		logic               arc;
		logic               wr;
		logic [FLAG_W-1:0]  flags;
		logic [LEVEL_W-1:0] level;
		logic [ADDR_W-1:0]  chan;
	} plan_t;

	// configuration
	logic [LEVEL_W-1:0] lower_q, upper_q, step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q <= LOWER_RST;
			upper_q <= UPPER_RST;
			step_q  <= STEP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LOWER: lower_q <= cfg_data;
				CFG_UPPER: upper_q <= cfg_data;
				CFG_STEP:  step_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// captured request
	op_t                op_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [ACT_W-1:0]   act_q;
	logic [LEVEL_W-1:0] lv_q;

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			op_q   <= op_t'(req_operation);
			addr_q <= req_address;
			act_q  <= req_touch_code;
			lv_q   <= req_level;
		end
	end

	logic [IDX_W-1:0] idx;
	logic             addr_ok;

	assign addr_ok = (addr_q == BROADCAST_ADDR) || (addr_q < ADDR_W'(CHANNEL_COUNT));
	assign idx     = (addr_q == BROADCAST_ADDR) ? BCAST_ENTRY : addr_q[IDX_W-1:0];

	// channel memory; entries never written read as the reset state
	logic [ENTRY_W-1:0]       mem_q [CHANNEL_COUNT];
	logic [ENTRY_W-1:0]       rd_q;
	logic                     rd_vld_q;
	logic [IDX_W-1:0]         idx_q;
	logic [CHANNEL_COUNT-1:0] vld_q;
	plan_t                    plan_q;

	always_ff @(posedge clk) begin
		if (cmd.wb && plan_q.wr) begin
			mem_q[idx_q] <= {plan_q.flags, plan_q.level};
		end
		if (cmd.mem_rd) begin
			rd_q     <= mem_q[idx];
			rd_vld_q <= vld_q[idx];
			idx_q    <= idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (cmd.wb && plan_q.wr) begin
			vld_q[idx_q] <= 1'b1;
		end
	end

	logic [FLAG_W-1:0]  f_cur;
	logic [LEVEL_W-1:0] l_cur;

	assign f_cur = rd_vld_q ? rd_q[ENTRY_W-1:LEVEL_W] : FLAGS_RST;
	assign l_cur = rd_vld_q ? rd_q[LEVEL_W-1:0] : LEVEL_RST;

	// ramp step toward the limits
	logic [LEVEL_W:0]   up_sum, dn_floor;
	logic               up_hit, dn_move;
	logic [LEVEL_W-1:0] cur_up, cur_dn;

	assign up_sum   = {1'b0, l_cur} + {1'b0, step_q};
	assign up_hit   = up_sum >= {1'b0, upper_q};
	assign cur_up   = up_hit ? upper_q : up_sum[LEVEL_W-1:0];
	assign dn_floor = {1'b0, lower_q} + {1'b0, step_q};
	assign dn_move  = {1'b0, l_cur} > dn_floor;
	assign cur_dn   = dn_move ? (l_cur - step_q) : lower_q;

	plan_t p;

	always_comb begin
		p          = '0;
		p.kind0    = KIND_ARC;
		p.kind1    = KIND_REPORT;
		p.sel0     = VS_ZERO;
		p.sel1     = VS_ZERO;
		p.flags    = f_cur;
		p.level    = l_cur;
		p.chan     = addr_q;
		case (op_q)
			OP_BUTTON: begin
				case (act_q)
					BTN_CLOSED: begin
						if (!f_cur[F_ON]) begin
							p.res_cnt = 2'd1;
							p.sel0    = VS_NEW;
						end
					end
					BTN_SHORT: begin
						p.wr = 1'b1;
						if (f_cur[F_ON]) begin
							p.res_cnt     = 2'd2;
							p.kind0       = KIND_OFF;
							p.flags[F_ON] = 1'b0;
						end else begin
							p.res_cnt     = 2'd1;
							p.kind0       = KIND_REPORT;
							p.sel0        = VS_SCALED;
							p.need_div    = 1'b1;
							p.flags[F_ON] = 1'b1;
						end
					end
					BTN_HELD: begin
						p.wr          = 1'b1;
						p.flags[F_ON] = 1'b1;
						if (f_cur[F_LAST_UP]) begin
							p.flags[F_LAST_UP] = 1'b0;
							p.flags[F_UP]      = 1'b0;
							p.flags[F_DOWN]    = 1'b1;
						end else begin
							p.flags[F_LAST_UP] = 1'b1;
							p.flags[F_UP]      = 1'b1;
							p.flags[F_DOWN]    = 1'b0;
						end
					end
					BTN_OPEN: begin
						if (f_cur[F_UP] || f_cur[F_DOWN]) begin
							p.wr            = 1'b1;
							p.res_cnt       = 2'd1;
							p.kind0         = KIND_REPORT;
							p.sel0          = VS_SCALED;
							p.need_div      = 1'b1;
							p.flags[F_UP]   = 1'b0;
							p.flags[F_DOWN] = 1'b0;
						end
					end
					default: ;
				endcase
			end
			OP_SET_LEVEL: begin
				p.wr          = 1'b1;
				p.res_cnt     = 2'd2;
				if (lv_q == '0) begin
					p.kind0       = KIND_OFF;
					p.flags[F_ON] = 1'b0;
				end else begin
					p.sel0        = VS_NEW;
					p.sel1        = VS_INPUT;
					p.need_div    = 1'b1;
					p.arc         = 1'b1;
					p.flags[F_ON] = 1'b1;
				end
			end
			OP_TOGGLE: begin
				p.wr      = 1'b1;
				p.res_cnt = 2'd2;
				if (f_cur[F_ON]) begin
					p.kind0       = KIND_OFF;
					p.flags[F_ON] = 1'b0;
				end else begin
					p.sel0        = VS_NEW;
					p.sel1        = VS_SCALED;
					p.need_div    = 1'b1;
					p.flags[F_ON] = 1'b1;
				end
			end
			default: begin
				// ramp tick; the broadcast entry always reports as the broadcast address
				p.chan = (idx_q == BCAST_ENTRY) ? BROADCAST_ADDR : addr_q;
				if (f_cur[F_UP]) begin
					p.wr      = 1'b1;
					p.level   = cur_up;
					p.res_cnt = 2'd1;
					p.sel0    = VS_NEW;
					if (up_hit) begin
						p.flags[F_UP] = 1'b0;
						p.res_cnt     = 2'd2;
						p.sel1        = VS_SCALED;
						p.need_div    = 1'b1;
					end
				end else if (f_cur[F_DOWN]) begin
					p.wr      = 1'b1;
					p.level   = cur_dn;
					p.res_cnt = 2'd1;
					p.sel0    = VS_NEW;
					if (!dn_move) begin
						p.flags[F_DOWN] = 1'b0;
						p.res_cnt       = 2'd2;
						p.sel1          = VS_SCALED;
						p.need_div      = 1'b1;
					end
				end
			end
		endcase
	end

	// scaling: report = (clamp(level) - lower) * 254 / span + 1,
	// arc = (level - 1) * span / 254 + lower
	logic [LEVEL_W-1:0]   span, d_clamp, mul_a, mul_b, div_den;
	logic [DIV_NUM_W-1:0] prod_q, quo;
	logic [LEVEL_W-1:0]   scaled_q;
	logic                 div_busy;
	logic                 range_bad;

	assign range_bad = upper_q <= lower_q;
	assign span      = range_bad ? '0 : (upper_q - lower_q);
	assign d_clamp   = (plan_q.level < lower_q) ? lower_q :
		(plan_q.level > upper_q) ? upper_q : plan_q.level;
	assign mul_a     = plan_q.arc ? (lv_q - 8'd1) : (d_clamp - lower_q);
	assign mul_b     = plan_q.arc ? span : SCALE_FULL;
	assign div_den   = plan_q.arc ? SCALE_FULL : (upper_q - lower_q);

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= {{LEVEL_W{1'b0}}, mul_a} * {{LEVEL_W{1'b0}}, mul_b};
		end
	end

	tdl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (prod_q),
		.den    (div_den),
		.busy   (div_busy),
		.quo    (quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.dec) begin
			plan_q <= p;
		end else if (cmd.fin && plan_q.arc) begin
			plan_q.level <= quo[LEVEL_W-1:0] + lower_q;
		end
		if (cmd.fin && !plan_q.arc) begin
			scaled_q <= range_bad ? REPORT_MAX : (quo[LEVEL_W-1:0] + 8'd1);
		end
	end

	// result register
	logic               rsp_valid_q;
	kind_t              kind_sel;
	val_sel_t           val_sel;
	logic [LEVEL_W-1:0] val_mux;
	logic [KIND_W-1:0]  kind_q;
	logic [ADDR_W-1:0]  chan_q;
	logic [LEVEL_W-1:0] value_q;
	logic               last_q;

	assign kind_sel = cmd.out_sel ? plan_q.kind1 : plan_q.kind0;
	assign val_sel  = cmd.out_sel ? plan_q.sel1 : plan_q.sel0;

	always_comb begin
		case (val_sel)
			VS_NEW:    val_mux = plan_q.level;
			VS_SCALED: val_mux = scaled_q;
			VS_INPUT:  val_mux = lv_q;
			default:   val_mux = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			kind_q  <= kind_sel;
			chan_q  <= plan_q.chan;
			value_q <= val_mux;
			last_q  <= cmd.out_sel || (plan_q.res_cnt == 2'd1);
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign rsp_kind    = kind_q;
	assign rsp_channel = chan_q;
	assign rsp_value   = value_q;
	assign rsp_last    = last_q;

	assign sts.addr_ok  = addr_ok;
	assign sts.need_div = plan_q.need_div;
	assign sts.res_cnt  = plan_q.res_cnt;
	assign sts.div_busy = div_busy;
	assign sts.out_free = !rsp_valid_q || rsp_ready;

`ifndef NO_ASSERTIONS
	a_wb_index: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wb |-> idx_q <= BCAST_ENTRY)
		else $error("write-back index outside the channel table");
`endif

endmodule

// ----- hw/rtl/tdl_ctrl.sv -----
// controller state machine sequencing one request through the datapath
module tdl_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  tdl_pkg::tdl_sts_t  sts,
	output tdl_pkg::tdl_cmd_t  cmd
);
	import tdl_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_RD   = 10'b0000000010,
		S_DEC  = 10'b0000000100,
		S_MUL  = 10'b0000001000,
		S_DVS  = 10'b0000010000,
		S_DIV  = 10'b0000100000,
		S_FIN  = 10'b0001000000,
		S_WB   = 10'b0010000000,
		S_OUT0 = 10'b0100000000,
		S_OUT1 = 10'b1000000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = state_q == S_IDLE;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.cap = 1'b1;
					state_d = S_RD;
				end
			end
			S_RD: begin
				// unused addresses finish here with no result
				if (sts.addr_ok) begin
					cmd.mem_rd = 1'b1;
					state_d    = S_DEC;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_DEC: begin
				cmd.dec = 1'b1;
				state_d = S_MUL;
			end
			S_MUL: begin
				if (sts.need_div) begin
					cmd.mul = 1'b1;
					state_d = S_DVS;
				end else begin
					state_d = S_WB;
				end
			end
			S_DVS: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIV;
			end
			S_DIV: begin
				if (!sts.div_busy) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				cmd.fin = 1'b1;
				state_d = S_WB;
			end
			S_WB: begin
				cmd.wb  = 1'b1;
				state_d = (sts.res_cnt == 2'd0) ? S_IDLE : S_OUT0;
			end
			S_OUT0: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = (sts.res_cnt == 2'd2) ? S_OUT1 : S_IDLE;
				end
			end
			S_OUT1: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result loaded while the result register is still held");
	a_div_runs: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> sts.div_busy)
		else $error("divider did not start");
	a_second_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OUT1 |-> sts.res_cnt == 2'd2)
		else $error("second result sequenced for a single-result request");
`endif

endmodule

// ----- hw/rtl/touch_dim_light_channel_controller.sv -----
// top level of the touch-dim light channel controller
// Takes one request at a time and answers with zero, one or two results on the
// result channel. A request to an unused address (81 to 126) ends after the
// address check; one that needs no scaling skips the multiplier and divider; one
// that scales a level (reports, set level, toggle on) multiplies, then starts and
// runs the shared one-bit-per-cycle divider. The channel state lives in an 81-entry
// memory with at most one read-modify-write per request; each result then waits
// until the result register is free, so a stalled result channel holds it back.
// The next request is taken while the last result still waits to be taken.
module touch_dim_light_channel_controller #(
	parameter int CHANNEL_COUNT = 81
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tdl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tdl_pkg::CFG_DATA_W-1:0]  cfg_data,
	tdl_req_if.sink                         request,
	tdl_rsp_if.source                       result
);
	import tdl_pkg::*;

	tdl_cmd_t           cmd;
	tdl_sts_t           sts;
	logic               req_ready;
	logic               rsp_valid;
	logic [KIND_W-1:0]  rsp_kind;
	logic [ADDR_W-1:0]  rsp_channel;
	logic [LEVEL_W-1:0] rsp_value;
	logic               rsp_last;

	tdl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (request.valid),
		.in_ready (req_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tdl_dp #(
		.CHANNEL_COUNT (CHANNEL_COUNT)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.req_operation     (request.operation),
		.req_address       (request.address),
		.req_touch_code    (request.touch_code),
		.req_level         (request.level),
		.rsp_valid         (rsp_valid),
		.rsp_ready         (result.ready),
		.rsp_kind          (rsp_kind),
		.rsp_channel       (rsp_channel),
		.rsp_value         (rsp_value),
		.rsp_last          (rsp_last)
	);

	assign request.ready  = req_ready;
	assign result.valid   = rsp_valid;
	assign result.kind    = rsp_kind;
	assign result.channel = rsp_channel;
	assign result.value   = rsp_value;
	assign result.last    = rsp_last;

endmodule
